### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the RTL files of the paren-run block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising aclk edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check a property on every rising aclk edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

### hw/rtl/lvpr_pkg.sv
// ----------------------------------------------------------------------------
// lvpr_pkg
// Payload types and fixed constants of the longest valid paren run block.
// ----------------------------------------------------------------------------
package lvpr_pkg;

    localparam int BEST_W = 11;

    localparam logic [7:0]        OPEN_SYMBOL = 8'd40;
    localparam logic [BEST_W-1:0] BEST_MAX    = 11'd2047;

    typedef struct packed {
        logic [7:0] symbol;
        logic       end_of_string;
    } in_item_t;

    typedef struct packed {
        logic [BEST_W-1:0] best_length;
        logic              too_long;
        logic              final_result;
    } result_t;

endpackage

### hw/rtl/lvpr_stack_mem.sv
// ----------------------------------------------------------------------------
// lvpr_stack_mem
// Position stack storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lvpr_stack_mem #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 11
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/lvpr_out_buf.sv
// ----------------------------------------------------------------------------
// lvpr_out_buf
// Two-entry result buffer: head register plus skid slot on the m_ side.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lvpr_out_buf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  lvpr_pkg::result_t push_data,
    output logic              full,
    output logic              m_valid,
    input  logic              m_ready,
    output lvpr_pkg::result_t m_data
);
    import lvpr_pkg::*;

    logic [1:0] cnt_reg, cnt_next;
    result_t    slot0_reg, slot0_next;
    result_t    slot1_reg, slot1_next;
    logic       pop;

    assign pop     = m_valid && m_ready;
    assign m_valid = (cnt_reg != 2'd0);
    assign m_data  = slot0_reg;
    assign full    = (cnt_reg == 2'd2);

    always_comb begin
        cnt_next   = cnt_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (push && !pop) begin
            if (cnt_reg == 2'd0) begin
                slot0_next = push_data;
            end else begin
                slot1_next = push_data;
            end
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            slot0_next = slot1_reg;
            cnt_next   = cnt_reg - 2'd1;
        end else if (push && pop) begin
            if (cnt_reg == 2'd1) begin
                slot0_next = push_data;
            end else begin
                slot0_next = slot1_reg;
                slot1_next = push_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    `ASSERT_CLK(a_no_push_when_full, push |-> (cnt_reg != 2'd2 || pop), "push into full result buffer")
    `ASSERT_CLK(a_cnt_bound, cnt_reg != 2'd3, "result buffer count out of range")

endmodule

### hw/rtl/longest_valid_paren_run.sv
// ----------------------------------------------------------------------------
// longest_valid_paren_run
// Streams one character per request and returns the longest well-formed
// parenthesis run seen so far in the current string.
// ----------------------------------------------------------------------------
// Each request's result is formed in the cycle after the request is taken,
// once the stack memory has returned the entry that a close uncovers; a
// new request is taken after that, while the buffer is not full. The stack
// lives in a MAX_LEN-entry synchronous memory with its top cached in a
// register, so no clearing pass is needed after reset or after the last
// character of a string. Results sit in a two-entry buffer, so a stalled m_
// side does not hold off the next request until both entries are full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module longest_valid_paren_run #(
    parameter int MAX_LEN = 1024
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  lvpr_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output lvpr_pkg::result_t   m_data
);
    import lvpr_pkg::*;

    localparam int SLOTS   = MAX_LEN + 1;
    localparam int POS_W   = $clog2(MAX_LEN + 1);
    localparam int DEPTH_W = $clog2(MAX_LEN + 2);
    localparam int AW      = $clog2(MAX_LEN);
    localparam int CMP_W   = (POS_W > BEST_W) ? POS_W : BEST_W;

    logic               busy_reg;
    logic               pop_pend_reg;
    logic               last_reg;
    logic [POS_W-1:0]   here_reg;
    logic [DEPTH_W-1:0] depth_reg;
    logic [POS_W-1:0]   top_reg;
    logic [POS_W-1:0]   counter_reg;
    logic [POS_W-1:0]   best_reg;
    logic               ovf_reg;

    logic               accept;
    logic               buf_full;
    logic               ovf_now;
    logic               is_open;
    logic [POS_W-1:0]   here;
    logic [DEPTH_W-1:0] depth_m1;
    logic [DEPTH_W-1:0] depth_m2;
    logic               mem_we;
    logic               mem_re;
    logic [POS_W-1:0]   mem_rdata;
    logic [POS_W-1:0]   span;
    logic [POS_W-1:0]   best_next;
    logic [CMP_W-1:0]   best_ext;
    result_t            result;

    assign s_ready  = !busy_reg && !buf_full;
    assign accept   = s_valid && s_ready;
    assign ovf_now  = (counter_reg >= POS_W'(MAX_LEN));
    assign is_open  = (s_data.symbol == OPEN_SYMBOL);
    assign here     = counter_reg + POS_W'(1);
    assign depth_m1 = depth_reg - DEPTH_W'(1);
    assign depth_m2 = depth_reg - DEPTH_W'(2);

    assign mem_we = accept && !ovf_now && is_open && (depth_reg < DEPTH_W'(SLOTS));
    assign mem_re = accept && !ovf_now && !is_open && (depth_reg != DEPTH_W'(1));

    lvpr_stack_mem #(
        .DEPTH  (MAX_LEN),
        .DATA_W (POS_W)
    ) u_stack_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (depth_m1[AW-1:0]),
        .wdata (top_reg),
        .re    (mem_re),
        .raddr (depth_m2[AW-1:0]),
        .rdata (mem_rdata)
    );

    // Span from the uncovered top to the closing position.
    always_comb begin
        span      = (here_reg >= mem_rdata) ? (here_reg - mem_rdata) : '0;
        best_next = best_reg;
        if (pop_pend_reg && (span > best_reg)) begin
            best_next = span;
        end
        best_ext = CMP_W'(best_next);
        result.best_length  = (best_ext > CMP_W'(BEST_MAX)) ? BEST_MAX
                                                              : best_ext[BEST_W-1:0];
        result.too_long     = ovf_reg;
        result.final_result = last_reg;
    end

    lvpr_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (busy_reg),
        .push_data (result),
        .full      (buf_full),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            pop_pend_reg <= 1'b0;
            depth_reg    <= DEPTH_W'(1);
            top_reg      <= '0;
            counter_reg  <= '0;
            best_reg     <= '0;
            ovf_reg      <= 1'b0;
        end else if (accept) begin
            busy_reg     <= 1'b1;
            pop_pend_reg <= mem_re;
            if (ovf_now) begin
                ovf_reg <= 1'b1;
            end else begin
                counter_reg <= here;
                if (is_open) begin
                    if (depth_reg < DEPTH_W'(SLOTS)) begin
                        top_reg   <= here;
                        depth_reg <= depth_reg + DEPTH_W'(1);
                    end
                end else if (depth_reg == DEPTH_W'(1)) begin
                    // Base popped: the closing position becomes the new base.
                    top_reg <= here;
                end else begin
                    depth_reg <= depth_m1;
                end
            end
        end else if (busy_reg) begin
            busy_reg     <= 1'b0;
            pop_pend_reg <= 1'b0;
            if (last_reg) begin
                depth_reg   <= DEPTH_W'(1);
                top_reg     <= '0;
                counter_reg <= '0;
                best_reg    <= '0;
                ovf_reg     <= 1'b0;
            end else begin
                best_reg <= best_next;
                if (pop_pend_reg) begin
                    top_reg <= mem_rdata;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            here_reg <= here;
            last_reg <= s_data.end_of_string;
        end
    end

    `ASSERT_CLK(a_one_in_flight, accept |=> (busy_reg && !s_ready), "request taken while busy")
    `ASSERT_CLK(a_result_follows, busy_reg |=> m_valid, "finished request left no result")
    `ASSERT_CLK(a_depth_nonzero, depth_reg != '0, "stack depth reached zero")
    `ASSERT_CLK(a_read_only_on_pop, pop_pend_reg |-> busy_reg, "stack read pending outside a request")

endmodule

### bench/paren_run_checker.sv
// ----------------------------------------------------------------------------
// paren_run_checker
// Watches both channels of the paren-run block, tracks the position stack of
// the current string and compares every result against the expected best run.
// ----------------------------------------------------------------------------
module paren_run_checker #(
    parameter int MAX_LEN = 1024
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  lvpr_pkg::in_item_t  s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  lvpr_pkg::result_t   m_data,
    output int                  mismatch_count,
    output int                  results_pending
);

    localparam int POS_W = $clog2(MAX_LEN + 2);

    // Entries hold position + 1, so zero stands for the base below position 0.
    logic [POS_W-1:0] pos_stack [0:MAX_LEN];
    logic [POS_W-1:0] stack_fill;
    logic [POS_W-1:0] char_count;
    logic [POS_W-1:0] best_run;
    logic             overflow_seen;

    lvpr_pkg::result_t expected_runs [$];
    int                errors = 0;

    function automatic void clear_tracker();
        pos_stack[0]  = '0;
        stack_fill    = POS_W'(1);
        char_count    = '0;
        best_run      = '0;
        overflow_seen = 1'b0;
    endfunction

    function automatic void push_position(input logic [POS_W-1:0] pos);
        if (stack_fill < MAX_LEN + 1) begin
            pos_stack[stack_fill] = pos;
            stack_fill = stack_fill + 1'b1;
        end
    endfunction

    function automatic lvpr_pkg::result_t track_symbol(input lvpr_pkg::in_item_t req);
        lvpr_pkg::result_t res;
        logic [POS_W-1:0]  pos;
        logic [POS_W-1:0]  top_pos;
        logic [POS_W-1:0]  span;
        if (char_count >= MAX_LEN) begin
            // String too long: flag it and leave everything else alone.
            overflow_seen = 1'b1;
        end else begin
            pos = char_count + 1'b1;
            if (req.symbol == lvpr_pkg::OPEN_SYMBOL) begin
                push_position(pos);
            end else begin
                if (stack_fill != 0) stack_fill = stack_fill - 1'b1;
                if (stack_fill == 0) begin
                    // Base popped: this close becomes the new base.
                    push_position(pos);
                end else begin
                    top_pos = pos_stack[stack_fill - 1'b1];
                    span    = (pos >= top_pos) ? pos - top_pos : '0;
                    if (span > best_run) best_run = span;
                end
            end
            char_count = char_count + 1'b1;
        end
        res.best_length  = (best_run > lvpr_pkg::BEST_MAX) ? lvpr_pkg::BEST_MAX
                                                          : lvpr_pkg::BEST_W'(best_run);
        res.too_long     = overflow_seen;
        res.final_result = req.end_of_string;
        if (req.end_of_string) clear_tracker();
        return res;
    endfunction

    function automatic void report_field(input string field, input int want, input int got);
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endfunction

    always @(posedge aclk) begin
        lvpr_pkg::result_t want;
        if (!aresetn) begin
            clear_tracker();
            expected_runs.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_runs.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual %0d/%0b/%0b",
                             $time, m_data.best_length, m_data.too_long,
                             m_data.final_result);
                end else begin
                    want = expected_runs.pop_front();
                    if (m_data.best_length !== want.best_length)
                        report_field("best_length", int'(want.best_length),
                                     int'(m_data.best_length));
                    if (m_data.too_long !== want.too_long)
                        report_field("too_long", int'(want.too_long),
                                     int'(m_data.too_long));
                    if (m_data.final_result !== want.final_result)
                        report_field("final_result", int'(want.final_result),
                                     int'(m_data.final_result));
                end
            end
            // A request's result never leaves in the cycle it is taken.
            if (s_valid && s_ready) expected_runs.push_back(track_symbol(s_data));
        end
        mismatch_count  <= errors;
        results_pending <= expected_runs.size();
    end

endmodule

### bench/longest_valid_paren_run_tb.sv
// ----------------------------------------------------------------------------
// longest_valid_paren_run_tb
// Feeds the paren-run block directed strings and random well-formed and
// broken strings, with random stalls on both channels; the checker beside
// the block predicts and compares every result.
// ----------------------------------------------------------------------------
module longest_valid_paren_run_tb;

    localparam int         MAX_LEN      = 1024;
    localparam int         RANDOM_ITEMS = 750;
    localparam int         CYCLE_LIMIT  = 1000000;
    localparam logic [7:0] CLOSE_PAREN  = 8'd41;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    lvpr_pkg::in_item_t s_data;
    logic               m_valid;
    logic               m_ready;
    lvpr_pkg::result_t  m_data;

    int fail_count;
    int results_pending;
    int cycle_count = 0;
    int chars_sent  = 0;
    bit quiet       = 1'b0;
    bit sender_calm = 1'b0;

    longest_valid_paren_run #(
        .MAX_LEN (MAX_LEN)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    paren_run_checker #(
        .MAX_LEN (MAX_LEN)
    ) i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .mismatch_count  (fail_count),
        .results_pending (results_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    function automatic logic [7:0] close_byte();
        logic [7:0] b;
        if ($urandom_range(0, 3) != 0) return CLOSE_PAREN;
        b = 8'($urandom_range(0, 255));
        if (b == lvpr_pkg::OPEN_SYMBOL) b = CLOSE_PAREN;
        return b;
    endfunction

    task automatic send_char(input logic [7:0] sym, input logic last);
        s_valid <= 1'b1;
        s_data  <= '{symbol: sym, end_of_string: last};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        chars_sent++;
        if (!quiet && !sender_calm && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++) send_char(txt[i], i == txt.len() - 1);
    endtask

    task automatic send_noise(input int len, input bit last_at_end);
        for (int i = 0; i < len; i++)
            send_char($urandom_range(0, 1) ? lvpr_pkg::OPEN_SYMBOL : close_byte(),
                      last_at_end && i == len - 1);
    endtask

    task automatic send_balanced(input int pairs, input bit last_at_end);
        int open_depth;
        int total;
        logic [7:0] sym;
        open_depth = 0;
        total      = 2 * pairs;
        for (int i = 0; i < total; i++) begin
            if (open_depth == total - i || (open_depth != 0 && $urandom_range(0, 1))) begin
                sym = close_byte();
                open_depth--;
            end else begin
                sym = lvpr_pkg::OPEN_SYMBOL;
                open_depth++;
            end
            send_char(sym, last_at_end && i == total - 1);
        end
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (results_pending != 0);
    endtask

    // Result side: alternate calm stretches with bursts of stalls.
    initial begin
        int chunk;
        bit calm;
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            calm  = ($urandom_range(0, 3) == 0);
            chunk = $urandom_range(40, 400);
            while (chunk > 0) begin
                if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
                    m_ready <= 1'b0;
                    repeat ($urandom_range(1, 18)) begin
                        @(posedge aclk);
                        chunk--;
                    end
                end else begin
                    m_ready <= 1'b1;
                    @(posedge aclk);
                    chunk--;
                end
            end
        end
    end

    initial begin
        int base;
        int string_idx;
        int kind;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_text(")()())");
        send_text("(()");
        send_text("(");
        send_text("()(())");
        // Bytes at both ends of the range close.
        send_char(lvpr_pkg::OPEN_SYMBOL, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(lvpr_pkg::OPEN_SYMBOL, 1'b0);
        send_char(8'h00, 1'b1);
        send_text(")");

        base       = chars_sent;
        string_idx = 0;
        while (chars_sent - base < RANDOM_ITEMS) begin
            sender_calm = ($urandom_range(0, 3) == 0);
            if (chars_sent - base > RANDOM_ITEMS - 120) quiet = 1'b1;
            if (string_idx == 10) wait_for_results();
            kind = $urandom_range(0, 9);
            if (kind <= 5) begin
                if ($urandom_range(0, 2) == 0) send_noise($urandom_range(1, 3), 1'b0);
                if ($urandom_range(0, 2) == 0) begin
                    send_balanced($urandom_range(1, 30), 1'b0);
                    send_noise($urandom_range(1, 3), 1'b1);
                end else begin
                    send_balanced($urandom_range(1, 30), 1'b1);
                end
            end else if (kind <= 8) begin
                send_noise($urandom_range(1, 40), 1'b1);
            end else begin
                // Break a valid run with a stray close.
                send_balanced($urandom_range(1, 15), 1'b0);
                send_char(close_byte(), 1'b0);
                send_balanced($urandom_range(1, 15), 1'b1);
            end
            string_idx++;
        end

        wait_for_results();
        repeat (10) @(posedge aclk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
